// ----- rtl/slot_allocator_free_used_lists_macros.svh -----
// Assertion macros used by the slot allocator checker.
`ifndef SLOT_ALLOCATOR_FREE_USED_LISTS_MACROS_SVH
`define SLOT_ALLOCATOR_FREE_USED_LISTS_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SAFUL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slot allocator port check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SAFUL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slot allocator port check failed");

`endif

// ----- rtl/saful_pkg.sv -----
// Shared types and constants of the slot allocator.
package saful_pkg;

  localparam int SLOTS_DEF = 1024;

  localparam int CFG_W   = 11;
  localparam int OP_W    = 3;
  localparam int IDX_W   = 10;
  localparam int STAT_W  = 2;
  localparam int TOTAL_W = 11;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  localparam int IN_OP_LSB     = 0;
  localparam int IN_IDX_LSB    = 3;
  localparam int OUT_STAT_LSB  = 0;
  localparam int OUT_IDX_LSB   = 2;
  localparam int OUT_FOUND_LSB = 12;
  localparam int OUT_TOTAL_LSB = 13;

  typedef enum logic [OP_W-1:0] {
    OP_FORMAT  = 3'd0,
    OP_ALLOC   = 3'd1,
    OP_RELEASE = 3'd2,
    OP_QUERY   = 3'd3,
    OP_HEAD    = 3'd4,
    OP_NEXT    = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_NONE   = 2'd1,
    STAT_RANGE  = 2'd2,
    STAT_UNUSED = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FMT,
    ST_A_T,
    ST_A_FW,
    ST_A_TW,
    ST_A_UR,
    ST_A_UW,
    ST_R_S,
    ST_R_NW,
    ST_R_PR,
    ST_R_PW,
    ST_R_SW,
    ST_R_FR,
    ST_R_FW,
    ST_Q_S,
    ST_H_R,
    ST_N_S,
    ST_N_T,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/saful_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module saful_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/slot_allocator_free_used_lists.sv -----
// Slot allocator: free list and doubly linked used list kept in one slot memory.
// Rejected or unknown operations go straight to the result; query and head read the slot
// memory once, next up to twice; allocate and release run a chain of reads and writes;
// format writes each active slot. The next item can be taken in the cycle after a result
// is registered; every memory access is one read or one write on the slot memory, which
// has one write and one read port. Reset clears all SLOTS entries before any item is taken.
module slot_allocator_free_used_lists #(
  parameter int SLOTS = saful_pkg::SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: [2:0] operation, [12:3] slot_index, [15:13] zero
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [saful_pkg::IN_TDATA_W-1:0]   in_tdata,
  // out_tdata: [1:0] status, [11:2] result_index, [12] found, [23:13] used_total
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [saful_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // active_slots register write
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [saful_pkg::CFG_W-1:0]        cfg_data
);

  import saful_pkg::*;

  // Address width and link width; a link equal to SLOTS means null.
  localparam int AW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);
  localparam logic [LW-1:0] NIL = LW'(SLOTS);
  localparam int RST_I = (int'(CFG_RESET) < SLOTS) ? int'(CFG_RESET) : SLOTS;
  localparam logic [LW-1:0] RST_CNT = LW'(RST_I);

  typedef struct packed {
    logic          in_use;
    logic [LW-1:0] nxt;
    logic [LW-1:0] prv;
  } ent_t;

  localparam int EW = $bits(ent_t);

  function automatic logic lnk_ok(input logic [LW-1:0] x);
    return x < NIL;
  endfunction

  // Control state
  state_t          state_r, state_nxt;
  logic [AW-1:0]   sw_r, sw_nxt;
  logic [LW-1:0]   fh_r, fh_nxt;        // free list head
  logic [LW-1:0]   uh_r, uh_nxt;        // used list head
  logic [LW-1:0]   cnt_r, cnt_nxt;      // used slot count
  logic [CFG_W-1:0] active_r;
  logic            out_valid_r, out_valid_nxt;

  // Item payload and scratch links
  logic [IDX_W-1:0] s_r, s_nxt;
  logic [LW-1:0]    ta_r, ta_nxt;
  logic [LW-1:0]    tb_r, tb_nxt;
  status_t          stat_r, stat_nxt;
  logic [IDX_W-1:0] res_r, res_nxt;
  logic             found_r, found_nxt;

  // Output register
  status_t            out_stat_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic               out_found_r;
  logic [TOTAL_W-1:0] out_total_r;

  // Memory port
  logic          mem_rd_en, mem_wr_en;
  logic [AW-1:0] mem_rd_addr, mem_wr_addr;
  ent_t          mem_wr_data;
  logic [EW-1:0] mem_rd_data;
  ent_t          rd_e;

  logic             acc;
  op_t              in_op;
  logic [IDX_W-1:0] in_s;
  logic [LW-1:0]    n;
  logic             s_ok, alloc_ok, head_ok, out_free, out_load;
  logic [LW-1:0]    sw_lim, sw_i;
  ent_t             sw_ent;

  assign rd_e  = ent_t'(mem_rd_data);
  assign acc   = in_tvalid && in_tready;
  assign in_op = op_t'(in_tdata[IN_OP_LSB +: OP_W]);
  assign in_s  = in_tdata[IN_IDX_LSB +: IDX_W];

  // Effective slot count: active_slots clamped to 1..SLOTS
  always_comb begin
    if (active_r == '0) begin
      n = LW'(1);
    end else if (32'(active_r) > 32'(SLOTS)) begin
      n = NIL;
    end else begin
      n = LW'(active_r);
    end
  end

  assign s_ok     = 32'(in_s) < 32'(n);
  assign alloc_ok = (cnt_r < n) && (fh_r < n);
  assign head_ok  = uh_r < n;
  assign out_free = !out_valid_r || out_tready;
  assign out_load = (state_r == ST_DONE) && out_free;

  // Sweep entry: chain 0..lim-1 on the free list, zero past the limit
  assign sw_lim = (state_r == ST_CLEAR) ? RST_CNT : n;
  assign sw_i   = LW'(sw_r);
  always_comb begin
    sw_ent = '0;
    if (sw_i < sw_lim) begin
      sw_ent.nxt = ((sw_i + LW'(1)) < sw_lim) ? (sw_i + LW'(1)) : NIL;
      sw_ent.prv = (sw_r == '0) ? NIL : (sw_i - LW'(1));
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sw_r == AW'(SLOTS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc) begin
          unique case (in_op)
            OP_FORMAT:  state_nxt = ST_FMT;
            OP_ALLOC:   state_nxt = alloc_ok ? ST_A_T : ST_DONE;
            OP_RELEASE: state_nxt = s_ok ? ST_R_S : ST_DONE;
            OP_QUERY:   state_nxt = s_ok ? ST_Q_S : ST_DONE;
            OP_HEAD:    state_nxt = head_ok ? ST_H_R : ST_DONE;
            OP_NEXT:    state_nxt = s_ok ? ST_N_S : ST_DONE;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_FMT: begin
        if (sw_r == AW'(n - LW'(1))) state_nxt = ST_DONE;
      end
      ST_A_T:  state_nxt = lnk_ok(rd_e.nxt) ? ST_A_FW : ST_A_TW;
      ST_A_FW: state_nxt = ST_A_TW;
      ST_A_TW: state_nxt = lnk_ok(uh_r) ? ST_A_UR : ST_DONE;
      ST_A_UR: state_nxt = ST_A_UW;
      ST_A_UW: state_nxt = ST_DONE;
      ST_R_S: begin
        priority if (!rd_e.in_use) state_nxt = ST_DONE;
        else if (lnk_ok(rd_e.nxt)) state_nxt = ST_R_NW;
        else if (lnk_ok(rd_e.prv)) state_nxt = ST_R_PW;
        else                       state_nxt = ST_R_SW;
      end
      ST_R_NW: state_nxt = lnk_ok(tb_r) ? ST_R_PR : ST_R_SW;
      ST_R_PR: state_nxt = ST_R_PW;
      ST_R_PW: state_nxt = ST_R_SW;
      ST_R_SW: state_nxt = lnk_ok(fh_r) ? ST_R_FR : ST_DONE;
      ST_R_FR: state_nxt = ST_R_FW;
      ST_R_FW: state_nxt = ST_DONE;
      ST_Q_S:  state_nxt = ST_DONE;
      ST_H_R:  state_nxt = ST_DONE;
      ST_N_S:  state_nxt = (rd_e.nxt < n) ? ST_N_T : ST_DONE;
      ST_N_T:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory accesses and register updates
  always_comb begin
    mem_rd_en     = 1'b0;
    mem_rd_addr   = '0;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = '0;
    mem_wr_data   = '0;
    sw_nxt        = sw_r;
    fh_nxt        = fh_r;
    uh_nxt        = uh_r;
    cnt_nxt       = cnt_r;
    s_nxt         = s_r;
    ta_nxt        = ta_r;
    tb_nxt        = tb_r;
    stat_nxt      = stat_r;
    res_nxt       = res_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;

    unique case (state_r)
      ST_CLEAR, ST_FMT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = sw_r;
        mem_wr_data = sw_ent;
        sw_nxt      = sw_r + AW'(1);
        if (state_r == ST_FMT && sw_r == AW'(n - LW'(1))) begin
          fh_nxt  = '0;
          uh_nxt  = NIL;
          cnt_nxt = '0;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          s_nxt     = in_s;
          stat_nxt  = STAT_OK;
          res_nxt   = '0;
          found_nxt = 1'b0;
          unique case (in_op)
            OP_FORMAT: sw_nxt = '0;
            OP_ALLOC: begin
              if (alloc_ok) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = AW'(fh_r);
                ta_nxt      = fh_r;
                res_nxt     = IDX_W'(fh_r);
                found_nxt   = 1'b1;
              end else begin
                stat_nxt = STAT_NONE;
              end
            end
            OP_RELEASE, OP_QUERY, OP_NEXT: begin
              if (s_ok) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = AW'(in_s);
              end else begin
                stat_nxt = STAT_RANGE;
              end
            end
            OP_HEAD: begin
              if (head_ok) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = AW'(uh_r);
              end else begin
                stat_nxt = STAT_NONE;
              end
            end
            default: ;
          endcase
        end
      end
      // Allocate: pop the free head, detach its successor, push at the used head
      ST_A_T: begin
        fh_nxt = rd_e.nxt;
        tb_nxt = rd_e.nxt;
        if (lnk_ok(rd_e.nxt)) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = AW'(rd_e.nxt);
        end
      end
      ST_A_FW: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = AW'(tb_r);
        mem_wr_data = '{in_use: rd_e.in_use, nxt: rd_e.nxt, prv: NIL};
      end
      ST_A_TW: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = AW'(ta_r);
        mem_wr_data = '{in_use: 1'b1, nxt: uh_r, prv: NIL};
        tb_nxt      = uh_r;
        uh_nxt      = ta_r;
        cnt_nxt     = cnt_r + LW'(1);
      end
      ST_A_UR: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = AW'(tb_r);
      end
      ST_A_UW: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = AW'(tb_r);
        mem_wr_data = '{in_use: rd_e.in_use, nxt: rd_e.nxt, prv: ta_r};
      end
      // Release: unlink from the used list, push at the free head
      ST_R_S: begin
        if (!rd_e.in_use) begin
          stat_nxt = STAT_UNUSED;
        end else begin
          ta_nxt = rd_e.nxt;
          tb_nxt = rd_e.prv;
          if (LW'(s_r) == uh_r) uh_nxt = rd_e.nxt;
          if (lnk_ok(rd_e.nxt)) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = AW'(rd_e.nxt);
          end else if (lnk_ok(rd_e.prv)) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = AW'(rd_e.prv);
          end
        end
      end
      ST_R_NW: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = AW'(ta_r);
        mem_wr_data = '{in_use: rd_e.in_use, nxt: rd_e.nxt, prv: tb_r};
      end
      ST_R_PR: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = AW'(tb_r);
      end
      ST_R_PW: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = AW'(tb_r);
        mem_wr_data = '{in_use: rd_e.in_use, nxt: ta_r, prv: rd_e.prv};
      end
      ST_R_SW: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = AW'(s_r);
        mem_wr_data = '{in_use: 1'b0, nxt: fh_r, prv: NIL};
        ta_nxt      = fh_r;
        fh_nxt      = LW'(s_r);
        cnt_nxt     = (cnt_r != '0) ? (cnt_r - LW'(1)) : '0;
        res_nxt     = s_r;
      end
      ST_R_FR: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = AW'(ta_r);
      end
      ST_R_FW: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = AW'(ta_r);
        mem_wr_data = '{in_use: rd_e.in_use, nxt: rd_e.nxt, prv: LW'(s_r)};
      end
      ST_Q_S: begin
        if (rd_e.in_use) begin
          res_nxt   = s_r;
          found_nxt = 1'b1;
        end else begin
          stat_nxt = STAT_UNUSED;
        end
      end
      ST_H_R: begin
        if (rd_e.in_use) begin
          res_nxt   = IDX_W'(uh_r);
          found_nxt = 1'b1;
        end else begin
          stat_nxt = STAT_NONE;
        end
      end
      ST_N_S: begin
        if (rd_e.nxt < n) begin
          ta_nxt      = rd_e.nxt;
          mem_rd_en   = 1'b1;
          mem_rd_addr = AW'(rd_e.nxt);
        end else begin
          stat_nxt = STAT_NONE;
        end
      end
      ST_N_T: begin
        if (rd_e.in_use) begin
          res_nxt   = IDX_W'(ta_r);
          found_nxt = 1'b1;
        end else begin
          stat_nxt = STAT_NONE;
        end
      end
      ST_DONE: ;
      default: ;
    endcase

    // Output register: load a finished item, drop it once taken
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      sw_r        <= '0;
      fh_r        <= '0;
      uh_r        <= NIL;
      cnt_r       <= '0;
      active_r    <= CFG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sw_r        <= sw_nxt;
      fh_r        <= fh_nxt;
      uh_r        <= uh_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        active_r <= cfg_data;
      end
    end
  end

  // Payload registers hold without reset
  always_ff @(posedge clk) begin
    s_r     <= s_nxt;
    ta_r    <= ta_nxt;
    tb_r    <= tb_nxt;
    stat_r  <= stat_nxt;
    res_r   <= res_nxt;
    found_r <= found_nxt;
    if (out_load) begin
      out_stat_r  <= stat_r;
      out_idx_r   <= res_r;
      out_found_r <= found_r;
      out_total_r <= TOTAL_W'(cnt_r);
    end
  end

  saful_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_slot_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_total_r, out_found_r, out_idx_r, out_stat_r};
  assign cfg_ready  = 1'b1;

endmodule

// ----- rtl/saful_chk.sv -----
// Port-level checker for the slot allocator, bound to its top level.
`include "slot_allocator_free_used_lists_macros.svh"

module saful_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [saful_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  import saful_pkg::*;

  logic [STAT_W-1:0] o_stat;
  logic [IDX_W-1:0]  o_idx;
  logic              o_found;

  assign o_stat  = out_tdata[OUT_STAT_LSB +: STAT_W];
  assign o_idx   = out_tdata[OUT_IDX_LSB +: IDX_W];
  assign o_found = out_tdata[OUT_FOUND_LSB];

  // A found slot is only reported with an ok status
  `SAFUL_ASSERT_IMP(a_found_ok, out_tvalid && o_found, o_stat == STAT_OK)
  // A failed operation names no slot
  `SAFUL_ASSERT_IMP(a_fail_empty, out_tvalid && o_stat != STAT_OK, !o_found && o_idx == '0)
  // A stalled result holds
  `SAFUL_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // One item in work at a time
  `SAFUL_ASSERT_NXT(a_one_item, in_tvalid && in_tready, !in_tready)

endmodule

bind slot_allocator_free_used_lists saful_chk u_saful_chk (.*);
